// ----- src/wdt_pkg.sv -----
// ---------------------------------------------------------------------------
// wdt_pkg: shared types and constants of the two-stage watchdog timer
// Command codes, register offsets, item and result words, reload function.
// ---------------------------------------------------------------------------
package wdt_pkg;

  localparam int RangeBase = 16;
  localparam int RangeMax  = 15;

  localparam int DataW = 32;
  localparam int AddrW = 8;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  localparam logic [AddrW-1:0] OffCr    = 8'h00;
  localparam logic [AddrW-1:0] OffRange = 8'h04;
  localparam logic [AddrW-1:0] OffCount = 8'h08;
  localparam logic [AddrW-1:0] OffKick  = 8'h0c;
  localparam logic [AddrW-1:0] OffStat  = 8'h10;
  localparam logic [AddrW-1:0] OffEoi   = 8'h14;

  localparam logic [DataW-1:0] KickValue = 32'h0000_0076;
  localparam int CrEnBit   = 0;
  localparam int CrRmodBit = 1;

  localparam logic [DataW-1:0] CountReset = 32'h0000_ffff;

  typedef struct packed {
    cmd_e             command;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             interrupt;
    logic             system_reset;
  } result_t;

  // Reload value for a range selector: 2^(RangeBase+sel)-1, saturating.
  function automatic logic [DataW-1:0] load_value(input logic [3:0] sel);
    int unsigned s;
    int unsigned e;
    s = int'(sel);
    if (s > RangeMax) s = RangeMax;
    e = RangeBase + s;
    if (e >= DataW) begin
      load_value = '1;
    end else begin
      load_value = (DataW'(1) << e) - DataW'(1);
    end
  endfunction

endpackage

// ----- src/wdt_in_stage.sv -----
// ---------------------------------------------------------------------------
// wdt_in_stage: input register
// Capture one command word per cycle while the slot is empty or advancing; free the slot as it advances.
// ---------------------------------------------------------------------------
module wdt_in_stage
  import wdt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_ready_o,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/wdt_core.sv -----
// ---------------------------------------------------------------------------
// wdt_core: watchdog register file and counter
// Apply one tick or bus access per advance and form its result word.
// ---------------------------------------------------------------------------
module wdt_core
  import wdt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic             enabled_q, enabled_d;
  logic             rmode_q, rmode_d;
  logic [3:0]       trange_q, trange_d;
  logic [3:0]       irange_q, irange_d;
  logic [DataW-1:0] count_q, count_d;
  logic             irq_q, irq_d;
  logic             rst_req_q, rst_req_d;
  logic [DataW-1:0] rd;

  always_comb begin
    enabled_d = enabled_q;
    rmode_d   = rmode_q;
    trange_d  = trange_q;
    irange_d  = irange_q;
    count_d   = count_q;
    irq_d     = irq_q;
    rst_req_d = rst_req_q;
    rd        = '0;
    case (item_i.command)
      CmdTick: begin
        if (enabled_q) begin
          if (count_q != '0) begin
            count_d = count_q - DataW'(1);
          end else begin
            // expiry: first one in interrupt mode warns, otherwise reset
            if (!rmode_q || irq_q) rst_req_d = 1'b1;
            else                   irq_d     = 1'b1;
            count_d = load_value(trange_q);
          end
        end
      end
      CmdRead: begin
        case (item_i.address)
          OffCr:    rd = {{(DataW-2){1'b0}}, rmode_q, enabled_q};
          OffRange: rd = {{(DataW-8){1'b0}}, irange_q, trange_q};
          OffCount: rd = count_q;
          OffStat:  rd = {{(DataW-1){1'b0}}, irq_q};
          OffEoi:   irq_d = 1'b0;
          default:  rd = '0;
        endcase
      end
      CmdWrite: begin
        case (item_i.address)
          OffCr: begin
            rmode_d = item_i.write_data[CrRmodBit];
            if (item_i.write_data[CrEnBit] && !enabled_q) begin
              enabled_d = 1'b1;
              count_d   = load_value(irange_q);
            end
          end
          OffRange: begin
            trange_d = item_i.write_data[3:0];
            irange_d = item_i.write_data[7:4];
          end
          OffKick: begin
            if (item_i.write_data == KickValue) begin
              count_d = load_value(trange_q);
              irq_d   = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      rmode_q   <= 1'b0;
      trange_q  <= '0;
      irange_q  <= '0;
      count_q   <= CountReset;
      irq_q     <= 1'b0;
      rst_req_q <= 1'b0;
    end else if (fire_i) begin
      enabled_q <= enabled_d;
      rmode_q   <= rmode_d;
      trange_q  <= trange_d;
      irange_q  <= irange_d;
      count_q   <= count_d;
      irq_q     <= irq_d;
      rst_req_q <= rst_req_d;
    end
  end

  assign result_o.read_data    = rd;
  assign result_o.interrupt    = irq_d;
  assign result_o.system_reset = rst_req_d;

`ifndef ASSERT_OFF
  a_reset_req_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_req_q |=> rst_req_q) else $error("reset request dropped");

  a_enable_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enabled_q |=> enabled_q) else $error("enable cleared");

  a_irq_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!irq_q ##1 irq_q) |-> ($past(fire_i) && $past(item_i.command) == CmdTick))
    else $error("interrupt raised without a tick");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(count_q)) else $error("count moved without a word");
`endif

endmodule

// ----- src/wdt_out_stage.sv -----
// ---------------------------------------------------------------------------
// wdt_out_stage: result register
// Hold the result word until the sink takes it.
// ---------------------------------------------------------------------------
module wdt_out_stage
  import wdt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- src/watchdog_timer_two_stage.sv -----
// Path: a word accepted into the input register passes through the state update into the result register.
// Throughput: one word per clock, set by the state update applied as a word moves from the
// input register to the result register; a stalled master side backs up the slave
// side once both registers hold a word.
// Reset: asynchronous, active low; clears both stages and loads the reset register
// values (disabled, ranges zero, count 0xFFFF, no interrupt, no reset request).
// ---------------------------------------------------------------------------
// watchdog_timer_two_stage: two-stage watchdog timer peripheral
// Ticks and bus accesses arrive as stream words; every word returns one
// result word with read data, the interrupt and the system reset request.
// ---------------------------------------------------------------------------
module watchdog_timer_two_stage
  import wdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: command words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] address, [39:8] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // master side: result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] read_data, [32] interrupt,
                                      // [33] system_reset, [39:34] zero
);

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    out_free;
  logic    advance;
  result_t res_d;
  result_t res_q;

  // Unpack the slave word into a command item.
  assign in_item.command    = cmd_e'(s_axis_tuser);
  assign in_item.address    = s_axis_tdata[7:0];
  assign in_item.write_data = s_axis_tdata[39:8];

  // Advance the held item whenever the result register can take its result.
  assign advance = cur_valid && out_free;

  wdt_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_item_i  (in_item),
    .in_ready_o (s_axis_tready),
    .advance_i  (advance),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  // Registers and counter change only as an item advances.
  wdt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (cur_item),
    .result_o (res_d)
  );

  wdt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (res_d),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res_q)
  );

  // Pack the result word, zero-filled to whole bytes.
  assign m_axis_tdata = {6'b0, res_q.system_reset, res_q.interrupt, res_q.read_data};

endmodule

// ----- test/wdt_result_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wdt_result_checker: result checker for the two-stage watchdog timer
// Watches both stream sides, keeps its own copy of the watchdog registers,
// predicts one result word per accepted command word and compares in order.
// ---------------------------------------------------------------------------
module wdt_result_checker
  import wdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] address, [39:8] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [31:0] read_data, [32] interrupt,
                                      // [33] system_reset, [39:34] zero
  output int          mismatch_count_o,
  output int          backlog_o
);

  logic             wd_enabled;
  logic             wd_rmode;
  logic [3:0]       tmo_sel;
  logic [3:0]       init_sel;
  logic [DataW-1:0] wd_count;
  logic             irq_flag;
  logic             rst_req;

  result_t watchdog_results_q[$];

  // Reload period for a range selector, saturating at the widest period.
  function automatic logic [DataW-1:0] period_of(input logic [3:0] sel);
    int unsigned sel_sat;
    int unsigned span;
    logic [63:0] ones;
    sel_sat = (sel > RangeMax) ? RangeMax : sel;
    span = RangeBase + sel_sat;
    ones = (64'd1 << span) - 64'd1;
    if (span >= DataW) return '1;
    return ones[DataW-1:0];
  endfunction

  task automatic advance_watchdog(input cmd_e cmd, input logic [AddrW-1:0] addr,
                                  input logic [DataW-1:0] data, output result_t res);
    res = '0;
    case (cmd)
      CmdTick: begin
        if (wd_enabled) begin
          if (wd_count != '0) begin
            wd_count = wd_count - 1'b1;
          end else begin
            if (!wd_rmode || irq_flag) rst_req = 1'b1;
            else irq_flag = 1'b1;
            wd_count = period_of(tmo_sel);
          end
        end
      end
      CmdRead: begin
        case (addr)
          OffCr: begin
            res.read_data[CrEnBit]   = wd_enabled;
            res.read_data[CrRmodBit] = wd_rmode;
          end
          OffRange: res.read_data = {24'b0, init_sel, tmo_sel};
          OffCount: res.read_data = wd_count;
          OffStat:  res.read_data = {31'b0, irq_flag};
          OffEoi:   irq_flag = 1'b0;
          default: ;
        endcase
      end
      CmdWrite: begin
        case (addr)
          OffCr: begin
            wd_rmode = data[CrRmodBit];
            // enable is sticky: only the first set loads the initial period
            if (data[CrEnBit] && !wd_enabled) begin
              wd_enabled = 1'b1;
              wd_count = period_of(init_sel);
            end
          end
          OffRange: begin
            tmo_sel  = data[3:0];
            init_sel = data[7:4];
          end
          OffKick: begin
            if (data == KickValue) begin
              wd_count = period_of(tmo_sel);
              irq_flag = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.interrupt    = irq_flag;
    res.system_reset = rst_req;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      wd_enabled = 1'b0;
      wd_rmode   = 1'b0;
      tmo_sel    = '0;
      init_sel   = '0;
      wd_count   = CountReset;
      irq_flag   = 1'b0;
      rst_req    = 1'b0;
      watchdog_results_q.delete();
      mismatch_count_o = 0;
      backlog_o = 0;
    end else begin
      // retire the oldest expectation first
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_data    = m_axis_tdata[31:0];
        got.interrupt    = m_axis_tdata[32];
        got.system_reset = m_axis_tdata[33];
        if (watchdog_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: unexpected result word %h", $realtime, m_axis_tdata);
        end else begin
          want = watchdog_results_q.pop_front();
          if (got.read_data != want.read_data || got.interrupt != want.interrupt ||
              got.system_reset != want.system_reset) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: result mismatch, expected rd=%h irq=%b rst=%b, got rd=%h irq=%b rst=%b",
                       $realtime, want.read_data, want.interrupt, want.system_reset,
                       got.read_data, got.interrupt, got.system_reset);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_watchdog(cmd_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8], want);
        watchdog_results_q.push_back(want);
      end
      backlog_o = watchdog_results_q.size();
    end
  end

endmodule

// ----- test/watchdog_timer_two_stage_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// watchdog_timer_two_stage_test: stimulus and verdict for the watchdog timer
// Drives directed register accesses, random command words and short tick runs
// with reloads and mode changes, with bursty input and a stalling output side.
// ---------------------------------------------------------------------------
module watchdog_timer_two_stage_test;
  import wdt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;    // [7:0] address, [39:8] write_data
  logic [1:0]  s_axis_tuser = CmdNop; // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] read_data, [32] interrupt,
                                     // [33] system_reset, [39:34] zero

  int mismatch_total;
  int result_backlog;
  int burst_left = 0;
  bit long_hold_req = 1'b0;

  logic [AddrW-1:0] reg_offsets [6] = '{OffCr, OffRange, OffCount, OffKick, OffStat, OffEoi};

  watchdog_timer_two_stage uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wdt_result_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_total),
    .backlog_o        (result_backlog)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("watchdog_timer_two_stage_test: done, errors");
    $finish;
  end

  // Result side: ready runs broken by short stalls, plus one long hold-off
  // on request so the block fills up and backs up the command side.
  initial begin : result_sink
    int run_len;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  end

  // Send one word; returns at the edge that accepts it. Gaps fall between bursts.
  task automatic push_word(input cmd_e cmd, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] data);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {data, addr};
    // sample ready mid-cycle, accept at the following edge
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    burst_left--;
  endtask

  // Drop valid and hold until every expected word has come back or the wait limit runs out.
  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (result_backlog != 0 && waited < 20000);
    @(posedge clk_i);
  endtask

  task automatic tick_run(input int n);
    repeat (n) push_word(CmdTick, AddrW'($urandom), $urandom);
  endtask

  task automatic push_random_word();
    int pick;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    cmd_e cmd;
    pick = $urandom_range(0, 99);
    addr = ($urandom_range(0, 6) == 0) ? AddrW'($urandom) : reg_offsets[$urandom_range(0, 5)];
    data = $urandom;
    if (pick < 40) begin
      cmd = CmdTick;
    end else if (pick < 68) begin
      cmd = CmdRead;
    end else if (pick < 94) begin
      cmd = CmdWrite;
      // mostly real kicks, the rest are ignored values
      if (addr == OffKick && $urandom_range(0, 3) != 0) data = KickValue;
    end else begin
      cmd = CmdNop;
    end
    push_word(cmd, addr, data);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values, disabled behavior, odd addresses and commands.
    push_word(CmdRead, OffCr, '0);
    push_word(CmdRead, OffRange, '0);
    push_word(CmdRead, OffCount, '0);
    push_word(CmdRead, OffStat, '0);
    push_word(CmdRead, OffEoi, '0);
    push_word(CmdRead, 8'hff, '1);
    push_word(CmdTick, 8'h00, '0);          // disabled: count holds
    push_word(CmdRead, OffCount, '0);
    push_word(CmdNop, 8'hff, '1);
    push_word(CmdWrite, OffRange, '1);      // widest ranges
    push_word(CmdRead, OffRange, '0);
    push_word(CmdWrite, OffKick, KickValue + 1'b1);
    push_word(CmdWrite, OffKick, KickValue); // kick while disabled reloads
    push_word(CmdRead, OffCount, '0);
    push_word(CmdWrite, OffCr, 32'h2);      // mode only, no enable
    push_word(CmdRead, OffCr, '0);
    push_word(CmdWrite, 8'h01, '1);         // near miss on an offset
    push_word(CmdWrite, OffCr, 32'h1);      // enable loads the initial period
    push_word(CmdRead, OffCount, '0);
    push_word(CmdTick, 8'hff, '1);
    push_word(CmdRead, OffCount, '0);
    push_word(CmdWrite, OffCr, 32'h0);      // enable cannot be cleared
    push_word(CmdRead, OffCr, '0);
    push_word(CmdWrite, OffRange, '0);      // count kept until next load
    push_word(CmdRead, OffCount, '0);
    push_word(CmdWrite, OffKick, KickValue);
    push_word(CmdRead, OffCount, '0);

    // Random traffic; start with a long output hold-off.
    long_hold_req = 1'b1;
    repeat (1350) push_random_word();
    drain_results();

    // Interrupt mode at the shortest range: run the counter, reload by kick,
    // switch modes and change ranges while it runs.
    push_word(CmdWrite, OffRange, '0);
    push_word(CmdWrite, OffCr, 32'h2);
    push_word(CmdWrite, OffKick, KickValue);
    tick_run(40);
    push_word(CmdRead, OffCount, '0);
    push_word(CmdRead, OffStat, '0);
    push_word(CmdRead, OffEoi, '0);
    push_word(CmdWrite, OffCr, 32'h0);
    push_word(CmdRead, OffCr, '0);
    push_word(CmdWrite, OffRange, 32'h0000_00ff);
    push_word(CmdRead, OffCount, '0);
    push_word(CmdWrite, OffKick, KickValue);
    push_word(CmdRead, OffCount, '0);
    tick_run(20);
    push_word(CmdRead, OffCount, '0);
    push_word(CmdRead, OffStat, '0);
    drain_results();

    repeat (200) push_random_word();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_total == 0 && result_backlog == 0) begin
      $display("watchdog_timer_two_stage_test: done, clean");
    end else begin
      $display("watchdog_timer_two_stage_test: done, errors");
    end
    $finish;
  end

endmodule
